FILE: sv/assert_macros.svh
// Assertion macros shared by the splitter RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define BPS_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define BPS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/bps_pkg.sv
// Types, codes and sizes for the BPE pre-token splitter.
// No dependencies; imported by every module of the block.
package bps_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QUEUE_DEPTH = 8;  // power of two, pointers wrap
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_APOS   = 4'd1,
    ST_APOS2  = 4'd2,
    ST_SPACE1 = 4'd3,
    ST_LET    = 4'd4,
    ST_PUNCT  = 4'd5,
    ST_SPP    = 4'd6,
    ST_SPN    = 4'd7,
    ST_SP     = 4'd8,
    ST_TAB    = 4'd9,
    ST_NL     = 4'd10
  } scan_state_t;

  localparam logic [3:0] KIND_CONTRACTION = 4'd0;
  localparam logic [3:0] KIND_APOS        = 4'd1;
  localparam logic [3:0] KIND_DIGIT       = 4'd2;
  localparam logic [3:0] KIND_NEWLINES    = 4'd3;
  localparam logic [3:0] KIND_SP_LETTERS  = 4'd4;
  localparam logic [3:0] KIND_SP_PUNCT    = 4'd5;
  localparam logic [3:0] KIND_SPACES      = 4'd6;
  localparam logic [3:0] KIND_TABS        = 4'd7;
  localparam logic [3:0] KIND_LETTERS     = 4'd8;
  localparam logic [3:0] KIND_PUNCT       = 4'd9;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       piece_end;
    logic [3:0] piece_kind;
    logic       text_end;
    logic       step_last;
  } out_item_t;

  // results of one request, item[0] first
  typedef struct packed {
    logic [1:0]                        n;
    out_item_t [MAX_RESULTS-1:0]       item;
  } step_res_t;

endpackage

FILE: sv/bpe_pretoken_splitter.sv
// Top level of the BPE pre-token splitter: input register, scanner, result queue.
// Depends on bps_pkg, bps_scanner and bps_result_queue.
//
//   channel | valid       | stall       | request
//   --------+-------------+-------------+---------------------------
//   text    | text_valid  | text_stall  | text_req  (byte, last flag)
//   piece   | piece_valid | piece_stall | piece_req (byte, end, kind, flags)
//
// One byte accepted per cycle while text_stall is low; the scanner classifies
// the registered byte once the queue has three free entries and writes 0 to 3
// results into an 8-entry queue, which registers them before they are offered.
// The queue drains one result per cycle while piece_stall is low. text_stall
// rises while the input register is full and fewer than three entries are free.
// rst (synchronous) empties the input register and queue and idles the scanner.
module bpe_pretoken_splitter (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  bps_pkg::in_item_t  text_req,
  output logic               piece_valid,
  input  logic               piece_stall,
  output bps_pkg::out_item_t piece_req
);
  import bps_pkg::*;

  in_item_t  in_reg;
  logic      in_full;
  logic      space_ok;
  logic      process;
  logic      accept;
  step_res_t step_res;

  assign process    = in_full && space_ok;
  assign text_stall = in_full && !space_ok;
  assign accept     = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= text_req;
    end
  end

  bps_scanner u_scanner (
    .clk  (clk),
    .rst  (rst),
    .fire (process),
    .item (in_reg),
    .res  (step_res)
  );

  bps_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (process),
    .wr        (step_res),
    .space_ok  (space_ok),
    .out_valid (piece_valid),
    .out_item  (piece_req),
    .out_stall (piece_stall)
  );

endmodule

FILE: sv/bps_scanner.sv
// Piece scanner: scan state registers and the per-byte classification step.
// Depends on bps_pkg and assert_macros.svh.
module bps_scanner (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  bps_pkg::in_item_t item,
  output bps_pkg::step_res_t res
);
  import bps_pkg::*;
  `include "assert_macros.svh"

  typedef struct packed {
    scan_state_t state;
    logic [7:0]  held0;
    logic [7:0]  held1;
    logic [1:0]  skip;
    logic [3:0]  kind;
  } scan_ctx_t;

  typedef struct packed {
    scan_ctx_t ctx;
    step_res_t res;
  } step_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC2);
  endfunction

  function automatic logic is_cont(logic [7:0] c);
    return c >= 8'h80 && c < 8'hC0;
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_nl(logic [7:0] c);
    return c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_symbol(logic [7:0] c);
    return c != 8'h20 && c != 8'h09 && !is_nl(c) && !is_letter(c) && !is_numeral(c)
           && c != 8'h27;
  endfunction

  function automatic logic [1:0] extra_bytes(logic [7:0] c);
    if (c < 8'h80) return 2'd0;
    if (c < 8'hE0) return 2'd1;
    if (c < 8'hF0) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic step_t emit(step_t t, logic [7:0] b, logic e, logic [3:0] k);
    step_t     u;
    out_item_t o;
    u            = t;
    o.out_byte   = b;
    o.piece_end  = e;
    o.piece_kind = k;
    o.text_end   = 1'b0;
    o.step_last  = 1'b0;
    if (u.res.n != 2'd3) begin
      u.res.item[u.res.n] = o;
      u.res.n             = u.res.n + 2'd1;
    end
    return u;
  endfunction

  function automatic step_t go_idle(step_t t);
    step_t u;
    u           = t;
    u.ctx.state = ST_IDLE;
    u.ctx.skip  = 2'd0;
    return u;
  endfunction

  function automatic step_t hold(step_t t, logic [7:0] b, scan_state_t st, logic [3:0] k);
    step_t u;
    u           = t;
    u.ctx.held0 = b;
    u.ctx.state = st;
    u.ctx.kind  = k;
    return u;
  endfunction

  function automatic step_t start_piece(step_t t, logic [7:0] b);
    step_t u;
    u          = t;
    u.ctx.skip = 2'd0;
    if (b == 8'h27) begin
      u = hold(u, b, ST_APOS, KIND_APOS);
    end else if (is_numeral(b)) begin
      u = emit(u, b, 1'b1, KIND_DIGIT);
      u = go_idle(u);
    end else if (is_nl(b)) begin
      u = hold(u, b, ST_NL, KIND_NEWLINES);
    end else if (b == 8'h20) begin
      u = hold(u, b, ST_SPACE1, KIND_SPACES);
    end else if (b == 8'h09) begin
      u = hold(u, b, ST_TAB, KIND_TABS);
    end else if (is_letter(b)) begin
      u          = hold(u, b, ST_LET, KIND_LETTERS);
      u.ctx.skip = extra_bytes(b);
    end else begin
      u = hold(u, b, ST_PUNCT, KIND_PUNCT);
    end
    return u;
  endfunction

  function automatic step_t run_feed(step_t t, logic [7:0] b);
    step_t      u;
    logic [7:0] p;
    logic [3:0] k;
    logic       cont;
    u    = t;
    p    = t.ctx.held0;
    k    = t.ctx.kind;
    cont = 1'b0;
    case (u.ctx.state)
      ST_LET: begin
        if (u.ctx.skip != 2'd0) begin
          u.ctx.skip = u.ctx.skip - 2'd1;
          cont       = 1'b1;
        end else if (is_letter(b) || is_cont(b)) begin
          u.ctx.skip = extra_bytes(b);
          cont       = 1'b1;
        end
      end
      ST_PUNCT: cont = is_symbol(b);
      ST_SPP: begin
        if (is_symbol(b)) begin
          cont = 1'b1;
        end else if (is_nl(b)) begin
          u.ctx.state = ST_SPN;
          cont        = 1'b1;
        end
      end
      ST_SPN:  cont = is_nl(b);
      ST_SP:   cont = (b == 8'h20);
      ST_TAB:  cont = (b == 8'h20) || (b == 8'h09);
      ST_NL:   cont = is_nl(b);
      default: cont = 1'b0;
    endcase
    if (cont) begin
      u           = emit(u, p, 1'b0, k);
      u.ctx.held0 = b;
    end else begin
      u = emit(u, p, 1'b1, k);
      u = go_idle(u);
      u = start_piece(u, b);
    end
    return u;
  endfunction

  function automatic step_t feed(step_t t, logic [7:0] b);
    step_t      u;
    logic [7:0] lb;
    logic [7:0] x;
    logic [7:0] lx;
    u  = t;
    lb = lower(b);
    x  = t.ctx.held1;
    lx = lower(x);
    case (u.ctx.state)
      ST_APOS: begin
        if (lb == 8'h73 || lb == 8'h74 || lb == 8'h6D || lb == 8'h64) begin
          u = emit(u, u.ctx.held0, 1'b0, KIND_CONTRACTION);
          u = emit(u, b, 1'b1, KIND_CONTRACTION);
          u = go_idle(u);
        end else if (lb == 8'h6C || lb == 8'h72 || lb == 8'h76) begin
          u.ctx.held1 = b;
          u.ctx.state = ST_APOS2;
        end else begin
          u = emit(u, u.ctx.held0, 1'b1, KIND_APOS);
          u = go_idle(u);
          u = start_piece(u, b);
        end
      end
      ST_APOS2: begin
        // 'll, 're, 've
        if ((lx == 8'h6C && lb == 8'h6C) || (lx == 8'h72 && lb == 8'h65) ||
            (lx == 8'h76 && lb == 8'h65)) begin
          u = emit(u, u.ctx.held0, 1'b0, KIND_CONTRACTION);
          u = emit(u, x, 1'b0, KIND_CONTRACTION);
          u = emit(u, b, 1'b1, KIND_CONTRACTION);
          u = go_idle(u);
        end else begin
          u = emit(u, u.ctx.held0, 1'b1, KIND_APOS);
          u = go_idle(u);
          u = start_piece(u, x);
          u = run_feed(u, b);
        end
      end
      ST_SPACE1: begin
        if (is_letter(b)) begin
          u          = emit(u, 8'h20, 1'b0, KIND_SP_LETTERS);
          u          = hold(u, b, ST_LET, KIND_SP_LETTERS);
          u.ctx.skip = extra_bytes(b);
        end else if (is_symbol(b)) begin
          u = emit(u, 8'h20, 1'b0, KIND_SP_PUNCT);
          u = hold(u, b, ST_SPP, KIND_SP_PUNCT);
        end else if (b == 8'h20) begin
          u = emit(u, 8'h20, 1'b0, KIND_SPACES);
          u = hold(u, b, ST_SP, KIND_SPACES);
        end else begin
          u = emit(u, 8'h20, 1'b1, KIND_SPACES);
          u = go_idle(u);
          u = start_piece(u, b);
        end
      end
      ST_LET, ST_PUNCT, ST_SPP, ST_SPN, ST_SP, ST_TAB, ST_NL: begin
        u = run_feed(u, b);
      end
      default: begin
        u = go_idle(u);
        u = start_piece(u, b);
      end
    endcase
    return u;
  endfunction

  function automatic step_t flush(step_t t);
    step_t u;
    u = t;
    case (u.ctx.state)
      ST_APOS:   u = emit(u, u.ctx.held0, 1'b1, KIND_APOS);
      ST_APOS2: begin
        u = emit(u, u.ctx.held0, 1'b1, KIND_APOS);
        u = emit(u, u.ctx.held1, 1'b1, KIND_LETTERS);
      end
      ST_SPACE1: u = emit(u, u.ctx.held0, 1'b1, KIND_SPACES);
      ST_LET, ST_PUNCT, ST_SPP, ST_SPN, ST_SP, ST_TAB, ST_NL: begin
        u = emit(u, u.ctx.held0, 1'b1, u.ctx.kind);
      end
      default: u = u;
    endcase
    return go_idle(u);
  endfunction

  scan_ctx_t ctx;
  scan_ctx_t ctx_next;
  step_t     t;

  always_comb begin
    t.ctx = ctx;
    t.res = '0;
    t     = feed(t, item.in_byte);
    if (item.text_last) begin
      t = flush(t);
    end
    if (t.res.n != 2'd0) begin
      t.res.item[t.res.n - 2'd1].step_last = 1'b1;
      t.res.item[t.res.n - 2'd1].text_end  = item.text_last;
    end
    ctx_next = t.ctx;
    res      = t.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state <= ST_IDLE;
      ctx.skip  <= 2'd0;
      ctx.kind  <= KIND_CONTRACTION;
    end else if (fire) begin
      ctx <= ctx_next;
    end
  end

  `BPS_ASSERT_IMPL(a_last_emits, clk, rst, fire && item.text_last, res.n != 2'd0, "end of text gave no result")
  `BPS_ASSERT_NEXT(a_last_idle, clk, rst, fire && item.text_last, ctx.state == ST_IDLE, "scanner not idle after text end")
  `BPS_ASSERT_IMPL(a_skip_let, clk, rst, ctx.skip != 2'd0, ctx.state == ST_LET, "skip count outside letter run")

endmodule

FILE: sv/bps_result_queue.sv
// Result queue: takes up to three results per cycle, hands out one per request.
// Depends on bps_pkg and assert_macros.svh.
module bps_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  bps_pkg::step_res_t wr,
  output logic               space_ok,
  output logic               out_valid,
  output bps_pkg::out_item_t out_item,
  input  logic               out_stall
);
  import bps_pkg::*;
  `include "assert_macros.svh"

  out_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  wr_ptr_next;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;
  logic [1:0]         wr_n;
  logic               pop;

  assign wr_n      = wr_en ? wr.n : 2'd0;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign space_ok  = (count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));

  assign wr_ptr_next = wr_ptr + QPTR_W'(wr_n);
  assign count_next  = count + QCNT_W'(wr_n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < wr_n) begin
        slots[wr_ptr + QPTR_W'(i)] <= wr.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  `BPS_ASSERT(a_cnt_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `BPS_ASSERT_IMPL(a_no_ovf, clk, rst, wr_en, space_ok, "write into queue without room")
  `BPS_ASSERT(a_ptr_gap, clk, rst, QPTR_W'(wr_ptr - rd_ptr) == QPTR_W'(count), "pointers disagree with count")

endmodule

FILE: test/bpe_pretoken_splitter_tb.sv
// Self-checking testbench for bpe_pretoken_splitter: drives text bytes, predicts
// the tagged piece bytes in a local scanner model and checks every result request.
// Depends on bps_pkg and the bpe_pretoken_splitter RTL.
module bpe_pretoken_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      text_valid = 1'b0;
  logic      text_stall;
  in_item_t  text_req = '0;
  logic      piece_valid;
  logic      piece_stall = 1'b0;
  out_item_t piece_req;

  bpe_pretoken_splitter i_dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_req   (text_req),
    .piece_valid(piece_valid),
    .piece_stall(piece_stall),
    .piece_req  (piece_req)
  );

  always #5 clk = ~clk;

  in_item_t    pending_text[$];
  out_item_t   expected_pieces[$];
  logic [7:0]  text_buf[$];
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // scanner model state
  scan_state_t sc_state = ST_IDLE;
  logic [7:0]  held0 = '0;
  logic [7:0]  held1 = '0;
  logic [1:0]  skip_n = '0;
  logic [3:0]  cur_kind = '0;
  out_item_t   step_buf[3];
  int          step_n;

  function automatic logic alpha_b(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b >= 8'hC2;
  endfunction

  function automatic logic cont_b(logic [7:0] b);
    return b >= 8'h80 && b < 8'hC0;
  endfunction

  function automatic logic digit_b(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic newline_b(logic [7:0] b);
    return b == "\n" || b == "\r";
  endfunction

  function automatic logic punct_b(logic [7:0] b);
    return b != " " && b != "\t" && !newline_b(b) && !alpha_b(b) && !digit_b(b) && b != "'";
  endfunction

  function automatic logic [1:0] utf8_tail(logic [7:0] b);
    if (b < 8'h80) return 2'd0;
    if (b < 8'hE0) return 2'd1;
    if (b < 8'hF0) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic void put_piece(logic [7:0] b, logic e, logic [3:0] k);
    out_item_t r;
    if (step_n >= 3) return;
    r.out_byte   = b;
    r.piece_end  = e;
    r.piece_kind = k;
    r.text_end   = 1'b0;
    r.step_last  = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endfunction

  function automatic void back_to_idle();
    sc_state = ST_IDLE;
    skip_n   = '0;
  endfunction

  function automatic void keep_byte(logic [7:0] b, scan_state_t st, logic [3:0] k);
    held0    = b;
    sc_state = st;
    cur_kind = k;
  endfunction

  function automatic void open_piece(logic [7:0] b);
    skip_n = '0;
    if (b == "'") keep_byte(b, ST_APOS, KIND_APOS);
    else if (digit_b(b)) begin
      put_piece(b, 1'b1, KIND_DIGIT);
      back_to_idle();
    end else if (newline_b(b)) keep_byte(b, ST_NL, KIND_NEWLINES);
    else if (b == " ") keep_byte(b, ST_SPACE1, KIND_SPACES);
    else if (b == "\t") keep_byte(b, ST_TAB, KIND_TABS);
    else if (alpha_b(b)) begin
      keep_byte(b, ST_LET, KIND_LETTERS);
      skip_n = utf8_tail(b);
    end else keep_byte(b, ST_PUNCT, KIND_PUNCT);
  endfunction

  function automatic logic run_goes_on(logic [7:0] b);
    logic go;
    go = 1'b0;
    case (sc_state)
      ST_LET: begin
        if (skip_n != 0) begin
          skip_n = skip_n - 2'd1;
          go = 1'b1;
        end else if (alpha_b(b) || cont_b(b)) begin
          skip_n = utf8_tail(b);
          go = 1'b1;
        end
      end
      ST_PUNCT: go = punct_b(b);
      ST_SPP: begin
        if (punct_b(b)) go = 1'b1;
        else if (newline_b(b)) begin
          sc_state = ST_SPN;
          go = 1'b1;
        end
      end
      ST_SPN:  go = newline_b(b);
      ST_SP:   go = (b == " ");
      ST_TAB:  go = (b == " " || b == "\t");
      ST_NL:   go = newline_b(b);
      default: go = 1'b0;
    endcase
    return go;
  endfunction

  function automatic void extend_run(logic [7:0] b);
    logic [7:0] p;
    logic [3:0] k;
    p = held0;
    k = cur_kind;
    if (run_goes_on(b)) begin
      put_piece(p, 1'b0, k);
      held0 = b;
    end else begin
      put_piece(p, 1'b1, k);
      back_to_idle();
      open_piece(b);
    end
  endfunction

  // expected pieces for one accepted text request
  function automatic void scan_byte(logic [7:0] b, logic last);
    logic [7:0] lb;
    logic [7:0] x;
    logic [7:0] lx;
    step_n = 0;
    lb = fold_case(b);
    case (sc_state)
      ST_IDLE: begin
        back_to_idle();
        open_piece(b);
      end
      ST_APOS: begin
        if (lb == "s" || lb == "t" || lb == "m" || lb == "d") begin
          put_piece(held0, 1'b0, KIND_CONTRACTION);
          put_piece(b, 1'b1, KIND_CONTRACTION);
          back_to_idle();
        end else if (lb == "l" || lb == "r" || lb == "v") begin
          held1    = b;
          sc_state = ST_APOS2;
        end else begin
          put_piece(held0, 1'b1, KIND_APOS);
          back_to_idle();
          open_piece(b);
        end
      end
      ST_APOS2: begin
        x  = held1;
        lx = fold_case(x);
        if ((lx == "l" && lb == "l") || (lx == "r" && lb == "e") || (lx == "v" && lb == "e")) begin
          put_piece(held0, 1'b0, KIND_CONTRACTION);
          put_piece(x, 1'b0, KIND_CONTRACTION);
          put_piece(b, 1'b1, KIND_CONTRACTION);
          back_to_idle();
        end else begin
          put_piece(held0, 1'b1, KIND_APOS);
          back_to_idle();
          open_piece(x);
          extend_run(b);
        end
      end
      ST_SPACE1: begin
        if (alpha_b(b)) begin
          put_piece(" ", 1'b0, KIND_SP_LETTERS);
          keep_byte(b, ST_LET, KIND_SP_LETTERS);
          skip_n = utf8_tail(b);
        end else if (punct_b(b)) begin
          put_piece(" ", 1'b0, KIND_SP_PUNCT);
          keep_byte(b, ST_SPP, KIND_SP_PUNCT);
        end else if (b == " ") begin
          put_piece(" ", 1'b0, KIND_SPACES);
          keep_byte(b, ST_SP, KIND_SPACES);
        end else begin
          put_piece(" ", 1'b1, KIND_SPACES);
          back_to_idle();
          open_piece(b);
        end
      end
      default: extend_run(b);
    endcase
    if (last) begin
      case (sc_state)
        ST_IDLE: ;
        ST_APOS: put_piece(held0, 1'b1, KIND_APOS);
        ST_APOS2: begin
          put_piece(held0, 1'b1, KIND_APOS);
          put_piece(held1, 1'b1, KIND_LETTERS);
        end
        ST_SPACE1: put_piece(held0, 1'b1, KIND_SPACES);
        default: put_piece(held0, 1'b1, cur_kind);
      endcase
      back_to_idle();
    end
    if (step_n > 0) begin
      step_buf[step_n-1].step_last = 1'b1;
      if (last) step_buf[step_n-1].text_end = 1'b1;
    end
    for (int i = 0; i < step_n; i++) expected_pieces.insert(expected_pieces.size(), step_buf[i]);
  endfunction

  // stimulus construction
  function automatic void text_add(logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  function automatic logic [7:0] mix_case(logic [7:0] c);
    return c ^ 8'($urandom_range(1) * 32);
  endfunction

  function automatic void add_word();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) text_add(mix_case(8'($urandom_range(25)) + "a"));
  endfunction

  function automatic void add_punct();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (!punct_b(c)) c = 8'($urandom_range(255));
    text_add(c);
  endfunction

  function automatic void add_fragment();
    int sel;
    int n;
    logic [7:0] lead;
    sel = $urandom_range(12);
    case (sel)
      0: add_word();
      1: begin
        text_add("'");
        case ($urandom_range(6))
          0: text_add(mix_case("s"));
          1: text_add(mix_case("t"));
          2: text_add(mix_case("m"));
          3: text_add(mix_case("d"));
          4: begin
            text_add(mix_case("l"));
            text_add(mix_case("l"));
          end
          5: begin
            text_add(mix_case("r"));
            text_add(mix_case("e"));
          end
          default: begin
            text_add(mix_case("v"));
            text_add(mix_case("e"));
          end
        endcase
      end
      2: begin
        text_add("'");
        case ($urandom_range(2))
          0: text_add(mix_case("l"));
          1: text_add(mix_case("r"));
          default: text_add(mix_case("v"));
        endcase
        if ($urandom_range(1)) text_add(8'($urandom_range(255)));
      end
      3: begin
        text_add(" ");
        add_word();
      end
      4: begin
        text_add(" ");
        n = $urandom_range(1, 3);
        repeat (n) add_punct();
        n = $urandom_range(0, 2);
        repeat (n) text_add($urandom_range(1) ? "\n" : "\r");
      end
      5: begin
        n = $urandom_range(1, 4);
        repeat (n) text_add(" ");
      end
      6: begin
        text_add("\t");
        n = $urandom_range(0, 3);
        repeat (n) text_add($urandom_range(1) ? "\t" : " ");
      end
      7: begin
        n = $urandom_range(1, 3);
        repeat (n) text_add($urandom_range(1) ? "\n" : "\r");
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) text_add(8'($urandom_range(9)) + "0");
      end
      9: begin
        n = $urandom_range(1, 3);
        repeat (n) add_punct();
      end
      10, 11: begin
        lead = 8'($urandom_range(8'hC2, 8'hFF));
        text_add(lead);
        n = int'(utf8_tail(lead));
        repeat (n) text_add(8'($urandom_range(8'h80, 8'hBF)));
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) text_add(8'($urandom_range(255)));
      end
    endcase
  endfunction

  function automatic void queue_text();
    in_item_t it;
    foreach (text_buf[i]) begin
      it.in_byte   = text_buf[i];
      it.text_last = (i == text_buf.size() - 1);
      pending_text.insert(pending_text.size(), it);
    end
    text_buf.delete();
  endfunction

  function automatic void queue_string(string s);
    for (int i = 0; i < s.len(); i++) text_add(s[i]);
    queue_text();
  endfunction

  function automatic void make_text();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) add_fragment();
    queue_text();
  endfunction

  // text channel driver
  always @(posedge clk) begin : drive_text
    logic go;
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && !text_stall) scan_byte(text_req.in_byte, text_req.text_last);
      if (!text_valid || !text_stall) begin
        go = pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (go) text_req <= pending_text.pop_front();
        text_valid <= go;
      end
    end
  end

  // piece channel receiver, with a single long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      piece_stall <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left <= 300;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      piece_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // piece channel monitor
  always @(posedge clk) begin : check_pieces
    out_item_t want;
    if (!rst && piece_valid && !piece_stall) begin
      if (expected_pieces.size() == 0) begin
        $error("piece request with none expected: byte %0h", piece_req.out_byte);
        n_errors++;
      end else begin
        want = expected_pieces.pop_front();
        check_field("out_byte", want.out_byte, piece_req.out_byte);
        check_field("piece_end", 8'(want.piece_end), 8'(piece_req.piece_end));
        check_field("piece_kind", 8'(want.piece_kind), 8'(piece_req.piece_kind));
        check_field("text_end", 8'(want.text_end), 8'(piece_req.text_end));
        check_field("step_last", 8'(want.step_last), 8'(piece_req.step_last));
      end
    end
  end

  initial begin : run_stimulus
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    send_pct = '{0, 65, 0, 37};
    recv_pct = '{0, 0, 65, 37};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // contractions, broken contraction, space choices, runs, UTF-8, stray bytes
    queue_string("'t'LL've'rX");
    queue_string(" a\t9\n !\n  ");
    text_buf = '{8'hF0, 8'h80, 8'h00, 8'hFF};
    queue_text();
    text_buf = '{8'h85, 8'hC1, 8'hE0, 8'h80};
    queue_text();
    queue_string("'");
    queue_string("'v");
    queue_string(" ");
    while (pending_text.size() != 0 || text_valid) @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      if (ph == 0) hold_req = 1'b1;
      while (pending_text.size() < 110) make_text();
      while (pending_text.size() != 0 || text_valid) @(negedge clk);
    end

    recv_stall_pct = 0;
    while (expected_pieces.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (n_errors == 0) $display("** bpe_pretoken_splitter: PASSED **");
    else $display("** bpe_pretoken_splitter: FAILED **");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("** bpe_pretoken_splitter: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/bps_pkg.sv
sv/bps_scanner.sv
sv/bps_result_queue.sv
sv/bpe_pretoken_splitter.sv
test/bpe_pretoken_splitter_tb.sv
